>>> sv/multi_led_blink_pattern_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LED blink pattern engine
// Implication checks, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_LED_BLINK_PATTERN_ENGINE_ASSERT_SVH
`define MULTI_LED_BLINK_PATTERN_ENGINE_ASSERT_SVH

// Same-cycle implication
`define MLBPE_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("blink engine: same-cycle check failed");

// Next-cycle implication
`define MLBPE_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("blink engine: next-cycle check failed");

`endif

>>> sv/mlbpe_pkg.sv
// ----------------------------------------------------------------------------
// mlbpe_pkg
// Shared types, constants and pattern tables of the LED blink pattern engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlbpe_pkg;

    localparam int NUM_LEDS = 8;
    localparam int LED_AW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int OUT_BITS = 8;

    localparam logic [2:0] MODE_OFF = 3'd0;
    localparam logic [2:0] MODE_ON  = 3'd1;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET     = 2'd1,
        OP_ALL_ON  = 2'd2,
        OP_ALL_OFF = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [2:0] mode;
    } cmd_t;

    // One LED entry; durations follow from the blink mode.
    typedef struct packed {
        logic [2:0] mode;
        logic       lit;
        logic [5:0] count;
    } entry_t;

    function automatic logic [4:0] on_dur(input logic [2:0] m);
        logic [4:0] d;
        case (m)
            3'd2:    d = 5'd1;
            3'd3:    d = 5'd2;
            3'd4:    d = 5'd5;
            3'd5:    d = 5'd10;
            3'd6:    d = 5'd30;
            3'd7:    d = 5'd1;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] off_dur(input logic [2:0] m);
        logic [4:0] d;
        case (m)
            3'd2:    d = 5'd5;
            3'd3:    d = 5'd2;
            3'd4:    d = 5'd5;
            3'd5:    d = 5'd10;
            3'd6:    d = 5'd30;
            3'd7:    d = 5'd30;
            default: d = 5'd0;
        endcase
        return d;
    endfunction

endpackage

>>> sv/mlbpe_update.sv
// ----------------------------------------------------------------------------
// mlbpe_update
// Read-modify-write step for one LED entry: tick, set mode, all on, all off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlbpe_update (
    input  mlbpe_pkg::cmd_t   cmd,
    input  mlbpe_pkg::entry_t old_entry,
    output mlbpe_pkg::entry_t new_entry
);

    logic [4:0] on_d;
    logic [4:0] off_d;
    logic       lit_a;
    logic [5:0] cnt_a;
    logic       lit_b;
    logic [5:0] cnt_b;

    assign on_d  = mlbpe_pkg::on_dur(old_entry.mode);
    assign off_d = mlbpe_pkg::off_dur(old_entry.mode);

    always_comb
    begin
        lit_a = old_entry.lit;
        cnt_a = old_entry.count;
        if (lit_a && (cnt_a >= {1'b0, on_d}))
        begin
            lit_a = 1'b0;
            cnt_a = '0;
        end
        lit_b = lit_a;
        cnt_b = cnt_a;
        if (!lit_b && (cnt_b >= {1'b0, off_d}))
        begin
            lit_b = 1'b1;
            cnt_b = '0;
        end
    end

    always_comb
    begin
        new_entry = old_entry;
        case (cmd.opcode)
            mlbpe_pkg::OP_TICK:
            begin
                if (old_entry.mode == mlbpe_pkg::MODE_OFF)
                begin
                    new_entry.lit = 1'b0;
                end
                else if (old_entry.mode == mlbpe_pkg::MODE_ON)
                begin
                    new_entry.lit = 1'b1;
                end
                else
                begin
                    new_entry.lit   = lit_b;
                    new_entry.count = cnt_b + 6'd1;
                end
            end
            mlbpe_pkg::OP_SET:
            begin
                if (old_entry.mode != cmd.mode)
                begin
                    new_entry.mode = cmd.mode;
                    if (cmd.mode > mlbpe_pkg::MODE_ON)
                    begin
                        new_entry.count = '0;
                    end
                end
            end
            mlbpe_pkg::OP_ALL_ON:  new_entry.mode = mlbpe_pkg::MODE_ON;
            mlbpe_pkg::OP_ALL_OFF: new_entry.mode = mlbpe_pkg::MODE_OFF;
            default:               new_entry = old_entry;
        endcase
    end

endmodule

>>> sv/multi_led_blink_pattern_engine.sv
// Sequencing: a set-mode item sweeps its single entry and then delivers the
// levels; an out-of-range set-mode item goes straight to delivery; tick /
// all-on / all-off sweep all NUM_LEDS entries. A new item is taken only once
// the last one is delivered; the LED entry memory is visited one entry per cycle.
// Reset: asynchronous, active low; all LEDs read mode off, dark, count zero
// through per-entry valid bits, so items are taken in the first cycle after.
// ----------------------------------------------------------------------------
// multi_led_blink_pattern_engine
// Per-LED mode and blink state held in a memory; each item sweeps the entries
// it touches with a pipelined read-modify-write and returns the LED levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "multi_led_blink_pattern_engine_assert.svh"

module multi_led_blink_pattern_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // opcode[1:0], led_index[4:2], mode[7:5]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // led_levels[7:0]
);

    localparam int AW = mlbpe_pkg::LED_AW;
    localparam int N  = mlbpe_pkg::NUM_LEDS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(N - 1);

    mlbpe_pkg::state_t state_reg;
    mlbpe_pkg::state_t state_next;
    mlbpe_pkg::cmd_t   cmd_reg;
    mlbpe_pkg::cmd_t   cmd_next;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [N-1:0]      valid_reg;
    logic [N-1:0]      valid_next;
    logic [7:0]        levels_reg;
    logic [7:0]        levels_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_data_reg;
    logic [7:0]        out_data_next;

    mlbpe_pkg::entry_t mem [N];
    mlbpe_pkg::entry_t rd_data_reg;
    logic              rd_valid_reg;
    mlbpe_pkg::entry_t old_entry;
    mlbpe_pkg::entry_t new_entry;

    logic              accept;
    logic              mem_we;
    logic              last_entry;
    logic              idx_ok;
    logic              out_free;
    mlbpe_pkg::opcode_t in_op;

    assign in_op    = mlbpe_pkg::opcode_t'(s_axis_tdata[1:0]);
    assign idx_ok   = int'(s_axis_tdata[4:2]) < N;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign last_entry = (cmd_reg.opcode == mlbpe_pkg::OP_SET) || (addr_reg == LAST_ADDR);
    assign old_entry  = rd_valid_reg ? rd_data_reg : '0;

    mlbpe_update u_update (
        .cmd       (cmd_reg),
        .old_entry (old_entry),
        .new_entry (new_entry)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlbpe_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (in_op == mlbpe_pkg::OP_SET && !idx_ok)
                        state_next = mlbpe_pkg::ST_DONE;
                    else
                        state_next = mlbpe_pkg::ST_SWEEP;
                end
            end
            mlbpe_pkg::ST_SWEEP:
            begin
                if (last_entry)
                    state_next = mlbpe_pkg::ST_DONE;
            end
            mlbpe_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = mlbpe_pkg::ST_IDLE;
            end
            default: state_next = mlbpe_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        case (state_reg)
            mlbpe_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            mlbpe_pkg::ST_SWEEP: mem_we        = 1'b1;
            mlbpe_pkg::ST_DONE:  s_axis_tready = 1'b0;
            default:             s_axis_tready = 1'b0;
        endcase
    end

    // datapath
    always_comb
    begin
        cmd_next       = cmd_reg;
        addr_next      = addr_reg;
        valid_next     = valid_reg;
        levels_next    = levels_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            cmd_next.opcode = in_op;
            cmd_next.mode   = s_axis_tdata[7:5];
            addr_next       = (in_op == mlbpe_pkg::OP_SET) ? AW'(s_axis_tdata[4:2]) : '0;
        end

        if (mem_we)
        begin
            valid_next[addr_reg] = 1'b1;
            if (int'(addr_reg) < mlbpe_pkg::OUT_BITS)
                levels_next[3'(addr_reg)] = new_entry.lit;
            if (!last_entry)
                addr_next = addr_reg + AW'(1);
        end

        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        if (state_reg == mlbpe_pkg::ST_DONE && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = levels_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlbpe_pkg::ST_IDLE;
            addr_reg      <= '0;
            valid_reg     <= '0;
            levels_reg    <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            valid_reg     <= valid_next;
            levels_reg    <= levels_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= valid_reg[addr_next];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
    end

    // entry memory: write the current entry, read the next one
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= new_entry;
        rd_data_reg <= mem[addr_next];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `MLBPE_ASSERT_IMP(a_write_in_range, mem_we, addr_reg <= LAST_ADDR)
    `MLBPE_ASSERT_NXT(a_set_single_entry,
        state_reg == mlbpe_pkg::ST_SWEEP && cmd_reg.opcode == mlbpe_pkg::OP_SET,
        state_reg == mlbpe_pkg::ST_DONE)
    `MLBPE_ASSERT_NXT(a_accept_starts_work, accept,
        state_reg == mlbpe_pkg::ST_SWEEP || state_reg == mlbpe_pkg::ST_DONE)
    `MLBPE_ASSERT_NXT(a_done_delivers, state_reg == mlbpe_pkg::ST_DONE && out_free,
        m_axis_tvalid && state_reg == mlbpe_pkg::ST_IDLE)

endmodule
